### src/bmp_unpk_pkg.sv
// Package for the bitmap pixel row unpacker.
// Holds the depth codes and the configuration register indexes; no dependencies.
package bmp_unpk_pkg;

   typedef logic [2:0] depth_type;
   typedef logic [1:0] csr_index_type;

   localparam depth_type DEPTH_1BIT  = 3'd0;
   localparam depth_type DEPTH_4BIT  = 3'd1;
   localparam depth_type DEPTH_8BIT  = 3'd2;
   localparam depth_type DEPTH_24BIT = 3'd3;
   localparam depth_type DEPTH_32BIT = 3'd4;

   localparam csr_index_type CSR_PIXEL_DEPTH  = 2'd0;
   localparam csr_index_type CSR_IMAGE_WIDTH  = 2'd1;
   localparam csr_index_type CSR_IMAGE_HEIGHT = 2'd2;

   localparam int unsigned DIM_WIDTH = 13;

endpackage

### src/bmp_pixel_row_unpacker.sv
// Bitmap pixel row unpacker: turns raw pixel-array bytes into RGB pixels.
// Depends on bmp_unpk_pkg for depth codes and register indexes.
//
// Usage:
//   req_ channel carries raw pixel-array bytes in file order, row padding included.
//   rsp_ channel carries one pixel per item with row_end, frame_end and last flags.
//   csr_ port writes pixel_depth, image_width and image_height; write only while idle.
// Path: accepted byte to the byte register, then its pixel to the result register.
// Throughput: the result register takes at most one pixel per cycle, none while a
//   stalled pixel is held; a byte stays until its pixels are loaded: one in 8, 24
//   and 32-bit modes, two in 4-bit mode, up to eight in 1-bit mode (fewer at the
//   end of a row). Bytes that give no pixel (padding, blue/green/alpha bytes) pass
//   without waiting on the result register. The next byte is taken in the same
//   cycle that the current byte's last pixel is loaded.
// Reset: counters, phase and registers return to depth 24, width 1, height 1.
// Stall: while rsp_stall holds, the result stays put; the byte register fills and
//   then req_stall rises until the pending pixel can move on.
module bmp_pixel_row_unpacker #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [7:0]                               req_raw_byte,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [7:0]                               rsp_red,
   output logic [7:0]                               rsp_green,
   output logic [7:0]                               rsp_blue,
   output logic                                     rsp_row_end,
   output logic                                     rsp_frame_end,
   output logic                                     rsp_last,
   input  logic                                     csr_write,
   input  bmp_unpk_pkg::csr_index_type              csr_index,
   input  logic [bmp_unpk_pkg::DIM_WIDTH-1:0]       csr_data
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int SW = $clog2(4 * MAX_WIDTH + 1);
   localparam int DW = bmp_unpk_pkg::DIM_WIDTH;

   // configuration
   bmp_unpk_pkg::depth_type depth_ff;
   logic [DW-1:0]           width_ff;
   logic [DW-1:0]           height_ff;

   // byte register
   logic       work_valid_ff, work_valid_in;
   logic [7:0] work_byte_ff;
   logic [2:0] sub_ff, sub_in;

   // row and pixel state
   logic [SW-1:0] byte_in_row_ff, byte_in_row_in;
   logic [CW-1:0] column_ff, column_in;
   logic [HW-1:0] row_ff, row_in;
   logic [1:0]    phase_ff, phase_in;
   logic [7:0]    held_blue_ff, held_blue_in;
   logic [7:0]    held_green_ff, held_green_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] red_ff, green_ff, blue_ff;
   logic       row_end_ff, frame_end_ff, last_ff;

   logic [31:0] w_raw, h_raw, w_eff, h_eff, stride, bir_next;
   logic        col_ok, emit, more, step, out_free, accept, byte_done;
   logic [7:0]  px_r, px_g, px_b;
   logic [3:0]  nib;
   logic        bit_val;
   logic        px_row_end, px_frame_end;
   logic [1:0]  phase_step;
   logic        wide_mode;

   always_comb begin
      w_raw = 32'(width_ff);
      h_raw = 32'(height_ff);
      if (w_raw == 32'd0) begin
         w_eff = 32'd1;
      end else if (w_raw > 32'(MAX_WIDTH)) begin
         w_eff = 32'(MAX_WIDTH);
      end else begin
         w_eff = w_raw;
      end
      if (h_raw == 32'd0) begin
         h_eff = 32'd1;
      end else if (h_raw > 32'(MAX_HEIGHT)) begin
         h_eff = 32'(MAX_HEIGHT);
      end else begin
         h_eff = h_raw;
      end
      // row stride in bytes, padded to a multiple of four
      case (depth_ff)
         bmp_unpk_pkg::DEPTH_1BIT:  stride = ((w_eff + 32'd31) >> 5) << 2;
         bmp_unpk_pkg::DEPTH_4BIT:  stride = ((w_eff + 32'd7) >> 3) << 2;
         bmp_unpk_pkg::DEPTH_24BIT: stride = ((w_eff * 32'd3 + 32'd3) >> 2) << 2;
         bmp_unpk_pkg::DEPTH_32BIT: stride = w_eff << 2;
         default:                   stride = ((w_eff + 32'd3) >> 2) << 2;
      endcase
   end

   always_comb begin
      col_ok       = 32'(column_ff) < w_eff;
      bit_val      = work_byte_ff[3'd7 - sub_ff];
      nib          = sub_ff[0] ? work_byte_ff[3:0] : work_byte_ff[7:4];
      emit         = 1'b0;
      more         = 1'b0;
      wide_mode    = 1'b0;
      px_r         = work_byte_ff;
      px_g         = work_byte_ff;
      px_b         = work_byte_ff;
      phase_step   = 2'd0;
      case (depth_ff)
         bmp_unpk_pkg::DEPTH_1BIT: begin
            emit = col_ok;
            more = col_ok && (sub_ff != 3'd7) && (32'(column_ff) + 32'd1 < w_eff);
            px_r = {8{bit_val}};
            px_g = {8{bit_val}};
            px_b = {8{bit_val}};
         end
         bmp_unpk_pkg::DEPTH_4BIT: begin
            emit = col_ok;
            more = col_ok && (sub_ff == 3'd0) && (32'(column_ff) + 32'd1 < w_eff);
            // index * 17 repeats the nibble
            px_r = {nib, nib};
            px_g = {nib, nib};
            px_b = {nib, nib};
         end
         bmp_unpk_pkg::DEPTH_24BIT: begin
            wide_mode  = 1'b1;
            emit       = col_ok && (phase_ff == 2'd2);
            phase_step = (phase_ff >= 2'd2) ? 2'd0 : phase_ff + 2'd1;
            px_g       = held_green_ff;
            px_b       = held_blue_ff;
         end
         bmp_unpk_pkg::DEPTH_32BIT: begin
            wide_mode  = 1'b1;
            emit       = col_ok && (phase_ff == 2'd2);
            phase_step = phase_ff + 2'd1;
            px_g       = held_green_ff;
            px_b       = held_blue_ff;
         end
         default: begin
            emit = col_ok;
         end
      endcase
      px_row_end   = 32'(column_ff) == w_eff - 32'd1;
      px_frame_end = px_row_end && (32'(row_ff) == h_eff - 32'd1);
   end

   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      step      = work_valid_ff && (!emit || out_free);
      byte_done = step && !more;
      req_stall = work_valid_ff && !byte_done;
      accept    = req_valid && !req_stall;
      bir_next  = 32'(byte_in_row_ff) + 32'd1;

      work_valid_in  = accept ? 1'b1 : (byte_done ? 1'b0 : work_valid_ff);
      sub_in         = sub_ff;
      column_in      = column_ff;
      byte_in_row_in = byte_in_row_ff;
      row_in         = row_ff;
      phase_in       = phase_ff;
      held_blue_in   = held_blue_ff;
      held_green_in  = held_green_ff;

      if (step && emit) begin
         column_in = column_ff + CW'(1);
      end
      if (step && wide_mode && col_ok) begin
         phase_in = phase_step;
         if (phase_ff == 2'd0) begin
            held_blue_in = work_byte_ff;
         end
         if (phase_ff == 2'd1) begin
            held_green_in = work_byte_ff;
         end
      end
      if (step && more) begin
         sub_in = sub_ff + 3'd1;
      end
      if (byte_done) begin
         sub_in         = 3'd0;
         byte_in_row_in = bir_next[SW-1:0];
         // end of stride: restart the row and advance the row count
         if (bir_next >= stride) begin
            byte_in_row_in = '0;
            column_in      = '0;
            phase_in       = 2'd0;
            row_in         = (32'(row_ff) + 32'd1 >= h_eff) ? '0 : row_ff + HW'(1);
         end
      end

      if (step && emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff       <= bmp_unpk_pkg::DEPTH_24BIT;
         width_ff       <= DW'(1);
         height_ff      <= DW'(1);
         work_valid_ff  <= 1'b0;
         sub_ff         <= 3'd0;
         byte_in_row_ff <= '0;
         column_ff      <= '0;
         row_ff         <= '0;
         phase_ff       <= 2'd0;
         held_blue_ff   <= 8'd0;
         held_green_ff  <= 8'd0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               bmp_unpk_pkg::CSR_PIXEL_DEPTH:  depth_ff  <= csr_data[2:0];
               bmp_unpk_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
               bmp_unpk_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_data;
               default: ;
            endcase
         end
         work_valid_ff  <= work_valid_in;
         sub_ff         <= sub_in;
         byte_in_row_ff <= byte_in_row_in;
         column_ff      <= column_in;
         row_ff         <= row_in;
         phase_ff       <= phase_in;
         held_blue_ff   <= held_blue_in;
         held_green_ff  <= held_green_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         work_byte_ff <= req_raw_byte;
      end
      if (step && emit) begin
         red_ff       <= px_r;
         green_ff     <= px_g;
         blue_ff      <= px_b;
         row_end_ff   <= px_row_end;
         frame_end_ff <= px_frame_end;
         last_ff      <= !more;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_red       = red_ff;
   assign rsp_green     = green_ff;
   assign rsp_blue      = blue_ff;
   assign rsp_row_end   = row_end_ff;
   assign rsp_frame_end = frame_end_ff;
   assign rsp_last      = last_ff;

   a_idle_takes_item: assert property (@(posedge clock) disable iff (reset)
      !work_valid_ff |-> !req_stall)
      else $error("byte register empty but input stalled");

   a_sub_needs_byte: assert property (@(posedge clock) disable iff (reset)
      sub_ff != 3'd0 |-> work_valid_ff)
      else $error("pixel index set without a held byte");

   a_emit_loads_result: assert property (@(posedge clock) disable iff (reset)
      step && emit |=> out_valid_ff)
      else $error("emitted pixel not held in result register");

   a_accept_on_finish: assert property (@(posedge clock) disable iff (reset)
      accept && work_valid_ff |-> byte_done)
      else $error("new byte taken while current byte still has pixels");

   a_frame_end_on_row_end: assert property (@(posedge clock) disable iff (reset)
      step && emit && px_frame_end |=> rsp_row_end)
      else $error("frame end without row end");

endmodule

### tb/bmp_pixel_row_unpacker_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for bmp_pixel_row_unpacker: byte driver, pixel monitor, predictor.
// Depends on bmp_unpk_pkg and the unpacker RTL; needs no files or arguments.
module bmp_pixel_row_unpacker_tb;

   typedef logic [bmp_unpk_pkg::DIM_WIDTH-1:0] dim_type;

   localparam int MAX_WIDTH_PX  = 4096;
   localparam int MAX_HEIGHT_PX = 4096;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int LONG_HOLD     = 300;
   localparam bmp_unpk_pkg::depth_type     DEPTH_UNKNOWN = 3'd7;
   localparam bmp_unpk_pkg::csr_index_type CSR_UNUSED    = 2'd3;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       row_end;
      logic       frame_end;
      logic       last;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [7:0]                  req_raw_byte = 8'h00;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [7:0]                  rsp_red, rsp_green, rsp_blue;
   logic                        rsp_row_end, rsp_frame_end, rsp_last;
   logic                        csr_write = 1'b0;
   bmp_unpk_pkg::csr_index_type csr_index = bmp_unpk_pkg::CSR_PIXEL_DEPTH;
   dim_type                     csr_data = '0;

   // predictor copy of the registers and the unpacking state
   bmp_unpk_pkg::depth_type cfg_depth  = bmp_unpk_pkg::DEPTH_24BIT;
   dim_type                 cfg_width  = 13'd1;
   dim_type                 cfg_height = 13'd1;
   logic [13:0]             byte_pos   = '0;
   logic [12:0]             col_pos    = '0;
   logic [11:0]             row_idx    = '0;
   logic [1:0]              bgr_phase  = '0;
   logic [7:0]              kept_blue  = '0;
   logic [7:0]              kept_green = '0;

   logic [7:0] bytes_to_send[$];
   pixel_type  pixels_due[$];

   int send_idle_pct = 27;
   int recv_idle_pct = 81;
   bit hold_armed    = 1'b0;
   bit hold_done     = 1'b0;
   int hold_left     = 0;
   int errors        = 0;
   int cycle_count   = 0;

   bmp_pixel_row_unpacker #(
      .MAX_WIDTH (MAX_WIDTH_PX),
      .MAX_HEIGHT(MAX_HEIGHT_PX)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_raw_byte (req_raw_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_red      (rsp_red),
      .rsp_green    (rsp_green),
      .rsp_blue     (rsp_blue),
      .rsp_row_end  (rsp_row_end),
      .rsp_frame_end(rsp_frame_end),
      .rsp_last     (rsp_last),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned eff_dim(input dim_type v, input int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   function automatic int unsigned depth_bits(input bmp_unpk_pkg::depth_type d);
      case (d)
         bmp_unpk_pkg::DEPTH_1BIT:  return 1;
         bmp_unpk_pkg::DEPTH_4BIT:  return 4;
         bmp_unpk_pkg::DEPTH_24BIT: return 24;
         bmp_unpk_pkg::DEPTH_32BIT: return 32;
         default:                   return 8;
      endcase
   endfunction

   function automatic int unsigned row_stride(input bmp_unpk_pkg::depth_type d,
                                              input int unsigned w);
      return ((w * depth_bits(d) + 31) / 32) * 4;
   endfunction

   // build one pixel at the current column and advance the column
   function automatic pixel_type make_pixel(input logic [7:0] r, g, b,
                                            input int unsigned w, h);
      pixel_type px;
      px.red       = r;
      px.green     = g;
      px.blue      = b;
      px.row_end   = (col_pos == w - 1);
      px.frame_end = px.row_end && (row_idx == h - 1);
      px.last      = 1'b0;
      col_pos      = col_pos + 1'b1;
      return px;
   endfunction

   task automatic unpack_byte(input logic [7:0] b);
      int unsigned w, h, bits, stride, per, nxt;
      int          n;
      pixel_type   batch[8];
      logic [7:0]  g;
      w      = eff_dim(cfg_width, MAX_WIDTH_PX);
      h      = eff_dim(cfg_height, MAX_HEIGHT_PX);
      bits   = depth_bits(cfg_depth);
      stride = row_stride(cfg_depth, w);
      n      = 0;
      if (bits == 1) begin
         for (int i = 0; i < 8 && col_pos < w; i++) begin
            g = b[7-i] ? 8'd255 : 8'd0;
            batch[n] = make_pixel(g, g, g, w, h);
            n++;
         end
      end else if (bits == 4) begin
         for (int i = 0; i < 2 && col_pos < w; i++) begin
            g = 8'((i == 0 ? b[7:4] : b[3:0]) * 17);
            batch[n] = make_pixel(g, g, g, w, h);
            n++;
         end
      end else if (bits == 8) begin
         if (col_pos < w) begin
            batch[n] = make_pixel(b, b, b, w, h);
            n++;
         end
      end else if (col_pos < w) begin
         per = bits / 8;
         case (bgr_phase)
            2'd0: kept_blue = b;
            2'd1: kept_green = b;
            2'd2: begin
               batch[n] = make_pixel(b, kept_green, kept_blue, w, h);
               n++;
            end
            default: ;
         endcase
         // a leftover alpha phase in 24-bit mode just drops the byte
         bgr_phase = (int'(bgr_phase) + 1 >= per) ? 2'd0 : bgr_phase + 1'b1;
      end
      for (int k = 0; k < n; k++) begin
         batch[k].last = (k == n - 1);
         pixels_due.push_back(batch[k]);
      end
      nxt = byte_pos + 1;
      if (nxt >= stride) begin
         byte_pos  = '0;
         col_pos   = '0;
         bgr_phase = '0;
         row_idx   = (int'(row_idx) + 1 >= h) ? 12'd0 : row_idx + 1'b1;
      end else begin
         byte_pos = nxt[13:0];
      end
   endtask

   // byte driver: offer the head of the queue, hold it while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            unpack_byte(req_raw_byte);
            void'(bytes_to_send.pop_front());
         end
         if (!(req_valid && req_stall)) begin
            if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid    <= 1'b1;
               req_raw_byte <= bytes_to_send[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_pixel();
      pixel_type seen, want;
      seen = '{rsp_red, rsp_green, rsp_blue, rsp_row_end, rsp_frame_end, rsp_last};
      if (pixels_due.size() == 0) begin
         errors++;
         $display("%0t: unexpected pixel r=%02h g=%02h b=%02h row_end=%b frame_end=%b last=%b",
                  $time, seen.red, seen.green, seen.blue, seen.row_end, seen.frame_end,
                  seen.last);
      end else begin
         want = pixels_due.pop_front();
         if (seen !== want) begin
            errors++;
            $display("%0t: pixel mismatch: expected r=%02h g=%02h b=%02h re=%b fe=%b last=%b",
                     $time, want.red, want.green, want.blue, want.row_end, want.frame_end,
                     want.last);
            $display("%0t:                   actual r=%02h g=%02h b=%02h re=%b fe=%b last=%b",
                     $time, seen.red, seen.green, seen.blue, seen.row_end, seen.frame_end,
                     seen.last);
         end
      end
   endtask

   // pixel monitor and receiver stall, with one long hold-off when armed
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_pixel();
         if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run did not finish in %0d cycles", $time, CYCLE_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   task automatic wait_idle();
      while (bytes_to_send.size() != 0 || pixels_due.size() != 0 || req_valid)
         @(negedge clock);
      // let a byte with no pixel clear the pipeline
      repeat (6) @(negedge clock);
   endtask

   task automatic program_regs(input bmp_unpk_pkg::depth_type d, input dim_type w, h);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= bmp_unpk_pkg::CSR_PIXEL_DEPTH;
      csr_data  <= {10'($urandom_range(0, 1023)), d};
      cfg_depth = d;
      @(posedge clock);
      csr_index <= bmp_unpk_pkg::CSR_IMAGE_WIDTH;
      csr_data  <= w;
      cfg_width = w;
      @(posedge clock);
      csr_index <= bmp_unpk_pkg::CSR_IMAGE_HEIGHT;
      csr_data  <= h;
      cfg_height = h;
      // no register sits at the spare index
      @(posedge clock);
      csr_index <= CSR_UNUSED;
      csr_data  <= 13'($urandom_range(0, 8191));
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic random_phase(input int send_pct, recv_pct, input bit arm_hold);
      int unsigned             sent, total, pick;
      bmp_unpk_pkg::depth_type d;
      dim_type                 w, h;
      bit                      first;
      first = 1'b1;
      sent  = 0;
      @(negedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      while (sent < 45) begin
         pick = $urandom_range(0, 19);
         d    = (pick < 17) ? bmp_unpk_pkg::depth_type'(pick % 5)
                            : bmp_unpk_pkg::depth_type'(pick - 12);
         w    = ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 8));
         h    = ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 3));
         // several rows keep bytes queued behind the held pixel
         if (arm_hold && first) h = 13'd3;
         wait_idle();
         program_regs(d, w, h);
         total = row_stride(d, eff_dim(w, MAX_WIDTH_PX)) * eff_dim(h, MAX_HEIGHT_PX);
         // now and then cut the frame short
         if ((!arm_hold || !first) && $urandom_range(0, 5) == 0)
            total = $urandom_range(1, total);
         @(negedge clock);
         repeat (total) bytes_to_send.push_back(8'($urandom_range(0, 255)));
         if (arm_hold && first) hold_armed = 1'b1;
         first = 1'b0;
         sent += total;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: one 24-bit pixel plus padding
      @(negedge clock);
      bytes_to_send.push_back(8'h01); bytes_to_send.push_back(8'h80);
      bytes_to_send.push_back(8'hFF); bytes_to_send.push_back(8'h00);
      wait_idle();
      program_regs(bmp_unpk_pkg::DEPTH_1BIT, 13'd9, 13'd2);
      @(negedge clock);
      bytes_to_send.push_back(8'h96); bytes_to_send.push_back(8'h80);
      bytes_to_send.push_back(8'h00); bytes_to_send.push_back(8'hFF);
      wait_idle();
      // height below the current row: the row end wraps to zero
      program_regs(bmp_unpk_pkg::DEPTH_4BIT, 13'd3, 13'd1);
      @(negedge clock);
      bytes_to_send.push_back(8'h0F); bytes_to_send.push_back(8'hF0);
      bytes_to_send.push_back(8'h5A); bytes_to_send.push_back(8'hA5);
      wait_idle();
      // unknown depth code, zero width, oversize height
      program_regs(DEPTH_UNKNOWN, 13'd0, 13'h1FFF);
      @(negedge clock);
      bytes_to_send.push_back(8'hC3); bytes_to_send.push_back(8'h3C);
      wait_idle();
      // 32-bit, oversize width, zero height; leave the phase on the alpha byte
      program_regs(bmp_unpk_pkg::DEPTH_32BIT, 13'h1FFF, 13'd0);
      @(negedge clock);
      bytes_to_send.push_back(8'h11); bytes_to_send.push_back(8'h22);
      bytes_to_send.push_back(8'h33); bytes_to_send.push_back(8'h44);
      bytes_to_send.push_back(8'h55); bytes_to_send.push_back(8'h66);
      bytes_to_send.push_back(8'h77);
      wait_idle();
      program_regs(bmp_unpk_pkg::DEPTH_24BIT, 13'd5, 13'd1);
      @(negedge clock);
      bytes_to_send.push_back(8'h99);
      wait_idle();
      // position already past the new stride: the row ends on this byte
      program_regs(bmp_unpk_pkg::DEPTH_8BIT, 13'd1, 13'd1);
      @(negedge clock);
      bytes_to_send.push_back(8'h42);

      random_phase(27, 81, 1'b0);
      random_phase(81, 27, 1'b0);
      random_phase(0, 0, 1'b1);

      while (bytes_to_send.size() != 0 || pixels_due.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (pixels_due.size() != 0) begin
         errors++;
         $display("%0t: %0d expected pixel(s) never arrived", $time, pixels_due.size());
      end
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### sim.f
src/bmp_unpk_pkg.sv
src/bmp_pixel_row_unpacker.sv
tb/bmp_pixel_row_unpacker_tb.sv
